### rtl/dwsl_pkg.sv
// Shared types and constants for the dual wheel slew limiter.
package dwsl_pkg;

    // Fixed field widths
    localparam int SPEED_BITS     = 32;
    localparam int LIMIT_W        = 31;
    localparam int TIME_W         = 20;
    localparam int TIME_FRAC_BITS = 20;
    localparam int PROD_W         = LIMIT_W + TIME_W;
    localparam int STEP_W         = PROD_W - TIME_FRAC_BITS;
    localparam int CALC_W         = SPEED_BITS + 2;
    localparam int CFG_IDX_W      = 3;

    typedef logic signed [SPEED_BITS-1:0] speed_t;
    typedef logic        [LIMIT_W-1:0]    limit_t;
    typedef logic        [TIME_W-1:0]     dtime_t;
    typedef logic        [STEP_W-1:0]     step_t;
    typedef logic signed [CALC_W-1:0]     calc_t;

    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_PRESET = 1'b1
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED_LEFT  = 3'd0,
        REG_MAX_SPEED_RIGHT = 3'd1,
        REG_MAX_ACCEL_LEFT  = 3'd2,
        REG_MAX_ACCEL_RIGHT = 3'd3,
        REG_MAX_DECEL_LEFT  = 3'd4,
        REG_MAX_DECEL_RIGHT = 3'd5
    } cfg_reg_t;

    // One lane after the speed clamp and step-limit products
    typedef struct packed {
        speed_t target;
        logic   speed_hit;
        step_t  step_acc;
        step_t  step_dec;
    } lane_prep_t;

    // One lane after rate limiting
    typedef struct packed {
        speed_t applied;
        logic   speed_hit;
        logic   accel_hit;
        logic   decel_hit;
    } lane_res_t;

endpackage

### rtl/dwsl_if.sv
// Command and response channel interfaces of the dual wheel slew limiter.
interface dwsl_cmd_if
    import dwsl_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    speed_t  raw_left;
    speed_t  raw_right;
    dtime_t  step_time;

    modport source (output valid, opcode, raw_left, raw_right, step_time, input ready);
    modport sink   (input valid, opcode, raw_left, raw_right, step_time, output ready);
endinterface

interface dwsl_rsp_if
    import dwsl_pkg::*;
();
    logic   valid;
    logic   ready;
    speed_t target_left;
    speed_t target_right;
    speed_t applied_left;
    speed_t applied_right;
    logic   speed_flag_left;
    logic   speed_flag_right;
    logic   accel_flag_left;
    logic   accel_flag_right;
    logic   decel_flag_left;
    logic   decel_flag_right;
    logic   result_valid;

    modport source (
        output valid, target_left, target_right, applied_left, applied_right,
               speed_flag_left, speed_flag_right, accel_flag_left, accel_flag_right,
               decel_flag_left, decel_flag_right, result_valid,
        input  ready
    );
    modport sink (
        input  valid, target_left, target_right, applied_left, applied_right,
               speed_flag_left, speed_flag_right, accel_flag_left, accel_flag_right,
               decel_flag_left, decel_flag_right, result_valid,
        output ready
    );
endinterface

### rtl/dual_wheel_slew_limiter.sv
// Dual wheel slew limiter top level: config registers, pipeline registers, kept speeds.
// Path: a word accepted on cmd passes three registers (input, clamp/product, result)
// before it shows on rsp.
// Throughput: one word per cycle while rsp is not stalled; the kept speeds update as a word
// enters the result register, so the next word sees them when it reaches the rate limiters.
// Reset: clears all valid bits, the six limit registers and both kept speeds to zero.
module dual_wheel_slew_limiter
    import dwsl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dwsl_cmd_if.sink             cmd,
    dwsl_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  limit_t               cfg_wdata
);

    // Configuration
    limit_t max_speed_left_reg;
    limit_t max_speed_right_reg;
    limit_t max_accel_left_reg;
    limit_t max_accel_right_reg;
    limit_t max_decel_left_reg;
    limit_t max_decel_right_reg;

    // Input register
    logic    s0_valid_reg;
    opcode_t s0_opcode_reg;
    speed_t  s0_raw_left_reg;
    speed_t  s0_raw_right_reg;
    dtime_t  s0_dt_reg;

    // Clamp/product register
    logic       s1_valid_reg;
    opcode_t    s1_opcode_reg;
    logic       s1_dt_zero_reg;
    speed_t     s1_raw_left_reg;
    speed_t     s1_raw_right_reg;
    lane_prep_t s1_prep_left_reg;
    lane_prep_t s1_prep_right_reg;

    // Kept speeds
    speed_t last_left_reg;
    speed_t last_right_reg;
    speed_t last_left_next;
    speed_t last_right_next;

    // Result register
    logic   out_valid_reg;
    speed_t out_target_left_reg;
    speed_t out_target_right_reg;
    speed_t out_applied_left_reg;
    speed_t out_applied_right_reg;
    logic   out_speed_left_reg;
    logic   out_speed_right_reg;
    logic   out_accel_left_reg;
    logic   out_accel_right_reg;
    logic   out_decel_left_reg;
    logic   out_decel_right_reg;
    logic   out_result_valid_reg;

    speed_t out_target_left_next;
    speed_t out_target_right_next;
    lane_res_t res_left_next;
    lane_res_t res_right_next;
    logic   out_result_valid_next;

    lane_prep_t prep_left;
    lane_prep_t prep_right;
    lane_res_t  res_left;
    lane_res_t  res_right;

    logic out_free;
    logic s1_free;
    logic s0_free;
    logic s1_move;
    logic s0_move;
    logic cmd_fire;

    // Pipeline flow control
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign s0_free   = !s0_valid_reg || s1_free;
    assign s1_move   = s1_valid_reg && out_free;
    assign s0_move   = s0_valid_reg && s1_free;
    assign cmd.ready = s0_free;
    assign cmd_fire  = cmd.valid && s0_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_left_reg  <= '0;
            max_speed_right_reg <= '0;
            max_accel_left_reg  <= '0;
            max_accel_right_reg <= '0;
            max_decel_left_reg  <= '0;
            max_decel_right_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_MAX_SPEED_LEFT:  max_speed_left_reg  <= cfg_wdata;
                REG_MAX_SPEED_RIGHT: max_speed_right_reg <= cfg_wdata;
                REG_MAX_ACCEL_LEFT:  max_accel_left_reg  <= cfg_wdata;
                REG_MAX_ACCEL_RIGHT: max_accel_right_reg <= cfg_wdata;
                REG_MAX_DECEL_LEFT:  max_decel_left_reg  <= cfg_wdata;
                REG_MAX_DECEL_RIGHT: max_decel_right_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_free)
        begin
            s0_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s0_opcode_reg    <= cmd.opcode;
            s0_raw_left_reg  <= cmd.raw_left;
            s0_raw_right_reg <= cmd.raw_right;
            s0_dt_reg        <= cmd.step_time;
        end
    end

    // Speed clamp and step-limit products
    dwsl_prep u_prep_left (
        .raw       (s0_raw_left_reg),
        .max_speed (max_speed_left_reg),
        .max_accel (max_accel_left_reg),
        .max_decel (max_decel_left_reg),
        .dt        (s0_dt_reg),
        .prep      (prep_left)
    );

    dwsl_prep u_prep_right (
        .raw       (s0_raw_right_reg),
        .max_speed (max_speed_right_reg),
        .max_accel (max_accel_right_reg),
        .max_decel (max_decel_right_reg),
        .dt        (s0_dt_reg),
        .prep      (prep_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            s1_opcode_reg     <= s0_opcode_reg;
            s1_dt_zero_reg    <= (s0_dt_reg == '0);
            s1_raw_left_reg   <= s0_raw_left_reg;
            s1_raw_right_reg  <= s0_raw_right_reg;
            s1_prep_left_reg  <= prep_left;
            s1_prep_right_reg <= prep_right;
        end
    end

    // Rate limiting against the kept speeds
    dwsl_lane u_lane_left (
        .prev      (last_left_reg),
        .prep      (s1_prep_left_reg),
        .max_speed (max_speed_left_reg),
        .res       (res_left)
    );

    dwsl_lane u_lane_right (
        .prev      (last_right_reg),
        .prep      (s1_prep_right_reg),
        .max_speed (max_speed_right_reg),
        .res       (res_right)
    );

    // Result and kept-speed selection by word kind
    always_comb
    begin
        out_target_left_next  = '0;
        out_target_right_next = '0;
        res_left_next         = '0;
        res_right_next        = '0;
        out_result_valid_next = 1'b0;
        last_left_next        = last_left_reg;
        last_right_next       = last_right_reg;
        if (s1_opcode_reg == OP_PRESET)
        begin
            last_left_next  = s1_raw_left_reg;
            last_right_next = s1_raw_right_reg;
        end
        else if (!s1_dt_zero_reg)
        begin
            out_target_left_next  = s1_prep_left_reg.target;
            out_target_right_next = s1_prep_right_reg.target;
            res_left_next         = res_left;
            res_right_next        = res_right;
            out_result_valid_next = 1'b1;
            last_left_next        = res_left.applied;
            last_right_next       = res_right.applied;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                last_left_reg  <= last_left_next;
                last_right_reg <= last_right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_target_left_reg   <= out_target_left_next;
            out_target_right_reg  <= out_target_right_next;
            out_applied_left_reg  <= last_left_next;
            out_applied_right_reg <= last_right_next;
            out_speed_left_reg    <= res_left_next.speed_hit;
            out_speed_right_reg   <= res_right_next.speed_hit;
            out_accel_left_reg    <= res_left_next.accel_hit;
            out_accel_right_reg   <= res_right_next.accel_hit;
            out_decel_left_reg    <= res_left_next.decel_hit;
            out_decel_right_reg   <= res_right_next.decel_hit;
            out_result_valid_reg  <= out_result_valid_next;
        end
    end

    // Response port
    assign rsp.valid            = out_valid_reg;
    assign rsp.target_left      = out_target_left_reg;
    assign rsp.target_right     = out_target_right_reg;
    assign rsp.applied_left     = out_applied_left_reg;
    assign rsp.applied_right    = out_applied_right_reg;
    assign rsp.speed_flag_left  = out_speed_left_reg;
    assign rsp.speed_flag_right = out_speed_right_reg;
    assign rsp.accel_flag_left  = out_accel_left_reg;
    assign rsp.accel_flag_right = out_accel_right_reg;
    assign rsp.decel_flag_left  = out_decel_left_reg;
    assign rsp.decel_flag_right = out_decel_right_reg;
    assign rsp.result_valid     = out_result_valid_reg;

endmodule

### rtl/dwsl_prep.sv
// Per-lane front end: speed clamp of the raw command and the two step-limit products.
module dwsl_prep
    import dwsl_pkg::*;
(
    input  speed_t     raw,
    input  limit_t     max_speed,
    input  limit_t     max_accel,
    input  limit_t     max_decel,
    input  dtime_t     dt,
    output lane_prep_t prep
);

    logic [PROD_W-1:0] acc_prod;
    logic [PROD_W-1:0] dec_prod;
    calc_t             raw_c;
    calc_t             lim_c;
    calc_t             neg_lim_c;

    // limit * dt in Q0.20, truncated back to the limit's scale
    assign acc_prod = PROD_W'(max_accel) * PROD_W'(dt);
    assign dec_prod = PROD_W'(max_decel) * PROD_W'(dt);

    assign raw_c     = {{(CALC_W-SPEED_BITS){raw[SPEED_BITS-1]}}, raw};
    assign lim_c     = {{(CALC_W-LIMIT_W){1'b0}}, max_speed};
    assign neg_lim_c = -lim_c;

    // Magnitude clamp against the wheel's speed limit
    always_comb
    begin
        prep.step_acc  = acc_prod[PROD_W-1:TIME_FRAC_BITS];
        prep.step_dec  = dec_prod[PROD_W-1:TIME_FRAC_BITS];
        prep.speed_hit = 1'b1;
        if (raw_c > lim_c)
        begin
            prep.target = lim_c[SPEED_BITS-1:0];
        end
        else if (raw_c < neg_lim_c)
        begin
            prep.target = neg_lim_c[SPEED_BITS-1:0];
        end
        else
        begin
            prep.target    = raw;
            prep.speed_hit = 1'b0;
        end
    end

endmodule

### rtl/dwsl_lane.sv
// Per-lane rate limiter: moves the kept speed toward the target and clamps the sum.
module dwsl_lane
    import dwsl_pkg::*;
(
    input  speed_t     prev,
    input  lane_prep_t prep,
    input  limit_t     max_speed,
    output lane_res_t  res
);

    calc_t p;
    calc_t t;
    calc_t ca;
    calc_t cd;
    calc_t lim_c;
    calc_t neg_lim_c;
    calc_t magp;
    calc_t magt;
    calc_t mrev;
    calc_t delta;
    calc_t magd;
    calc_t ch;
    calc_t app;
    calc_t fin;
    logic  reversal;
    logic  rising;
    logic  acc_hit;
    logic  dec_hit;

    assign p         = {{(CALC_W-SPEED_BITS){prev[SPEED_BITS-1]}}, prev};
    assign t         = {{(CALC_W-SPEED_BITS){prep.target[SPEED_BITS-1]}}, prep.target};
    assign ca        = {{(CALC_W-STEP_W){1'b0}}, prep.step_acc};
    assign cd        = {{(CALC_W-STEP_W){1'b0}}, prep.step_dec};
    assign lim_c     = {{(CALC_W-LIMIT_W){1'b0}}, max_speed};
    assign neg_lim_c = -lim_c;

    assign magp  = p[CALC_W-1] ? -p : p;
    assign magt  = t[CALC_W-1] ? -t : t;
    assign delta = t - p;
    assign magd  = delta[CALC_W-1] ? -delta : delta;

    // Sign reversal: decay toward zero, never past it
    assign reversal = (prev != '0) && (prep.target != '0)
                      && (prev[SPEED_BITS-1] != prep.target[SPEED_BITS-1]);
    assign mrev     = (magp > cd) ? (magp - cd) : '0;

    assign rising = magt > magp;
    assign ch     = rising ? ca : cd;

    // Step selection
    always_comb
    begin
        acc_hit = 1'b0;
        dec_hit = 1'b0;
        if (reversal)
        begin
            app     = p[CALC_W-1] ? -mrev : mrev;
            dec_hit = cd < magp;
        end
        else if (magd > ch)
        begin
            app     = delta[CALC_W-1] ? (p - ch) : (p + ch);
            acc_hit = rising;
            dec_hit = !rising;
        end
        else
        begin
            app = t;
        end
    end

    // Final speed clamp on the new value
    always_comb
    begin
        if (app > lim_c)
        begin
            fin = lim_c;
        end
        else if (app < neg_lim_c)
        begin
            fin = neg_lim_c;
        end
        else
        begin
            fin = app;
        end
    end

    assign res.applied   = fin[SPEED_BITS-1:0];
    assign res.speed_hit = prep.speed_hit || (fin != app);
    assign res.accel_hit = acc_hit;
    assign res.decel_hit = dec_hit;

endmodule

### rtl/dwsl_checker.sv
// Port-level checks for the dual wheel slew limiter, bound to the top level.
module dwsl_port_checks
    import dwsl_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   rsp_valid,
    input logic   rsp_ready,
    input speed_t target_left,
    input speed_t target_right,
    input speed_t applied_left,
    input logic   speed_flag_left,
    input logic   speed_flag_right,
    input logic   accel_flag_left,
    input logic   accel_flag_right,
    input logic   decel_flag_left,
    input logic   decel_flag_right,
    input logic   result_valid
);

    // No response word while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(applied_left)
                                    && $stable(result_valid))
        else $error("stalled response word changed");

    // Preset and zero-time words carry no targets and no flags
    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !result_valid |-> target_left == '0 && target_right == '0
            && !speed_flag_left && !speed_flag_right && !accel_flag_left
            && !accel_flag_right && !decel_flag_left && !decel_flag_right)
        else $error("targets or flags set on a word without update");

    // One lane never cuts a step both ways
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(accel_flag_left && decel_flag_left)
                      && !(accel_flag_right && decel_flag_right))
        else $error("acceleration and deceleration flags both set");

endmodule

bind dual_wheel_slew_limiter dwsl_port_checks u_dwsl_port_checks (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .target_left      (rsp.target_left),
    .target_right     (rsp.target_right),
    .applied_left     (rsp.applied_left),
    .speed_flag_left  (rsp.speed_flag_left),
    .speed_flag_right (rsp.speed_flag_right),
    .accel_flag_left  (rsp.accel_flag_left),
    .accel_flag_right (rsp.accel_flag_right),
    .decel_flag_left  (rsp.decel_flag_left),
    .decel_flag_right (rsp.decel_flag_right),
    .result_valid     (rsp.result_valid)
);

### tb/dwsl_checker.sv
// Scoreboard for the dual wheel slew limiter: predicts each response word and compares it.
module dwsl_checker
    import dwsl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dwsl_cmd_if                  cmd,
    dwsl_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  limit_t               cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    // One wheel after clamping and rate limiting
    typedef struct {
        longint target;
        longint applied;
        logic   speed_hit;
        logic   accel_hit;
        logic   decel_hit;
    } wheel_step_t;

    // One response word as the block should produce it
    typedef struct {
        speed_t target_left;
        speed_t target_right;
        speed_t applied_left;
        speed_t applied_right;
        logic   speed_flag_left;
        logic   speed_flag_right;
        logic   accel_flag_left;
        logic   accel_flag_right;
        logic   decel_flag_left;
        logic   decel_flag_right;
        logic   result_valid;
    } wheel_rsp_t;

    // Limits and kept speeds, index 0 is the left wheel, 1 the right
    longint     speed_lim [2] = '{0, 0};
    longint     accel_lim [2] = '{0, 0};
    longint     decel_lim [2] = '{0, 0};
    longint     kept      [2] = '{0, 0};
    wheel_rsp_t wheel_rsp_due [$];
    int         errs = 0;

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // limit * dt in Q0.20 seconds, truncated
    function automatic longint step_of(longint limit, longint dt);
        return (limit * dt) >> TIME_FRAC_BITS;
    endfunction

    // Clamp the raw command, then slew the kept speed of one wheel toward it
    function automatic wheel_step_t limit_wheel(longint raw, int wheel, longint dt);
        wheel_step_t r;
        longint      prev;
        longint      ch;
        longint      m;
        longint      delta;
        longint      fin;
        bit          rising;
        prev        = kept[wheel];
        r.target    = clamp_mag(raw, speed_lim[wheel]);
        r.speed_hit = (r.target != raw);
        r.accel_hit = 1'b0;
        r.decel_hit = 1'b0;
        if (prev != 0 && r.target != 0 && ((prev < 0) != (r.target < 0))) begin
            // sign reversal: decay toward zero, never cross it
            ch = step_of(decel_lim[wheel], dt);
            m  = mag_of(prev) - ch;
            if (m < 0)
                m = 0;
            r.applied   = (prev < 0) ? -m : m;
            r.decel_hit = (ch < mag_of(prev));
        end
        else begin
            delta  = r.target - prev;
            rising = (mag_of(r.target) > mag_of(prev));
            ch     = step_of(rising ? accel_lim[wheel] : decel_lim[wheel], dt);
            if (mag_of(delta) > ch) begin
                r.applied   = (delta < 0) ? prev - ch : prev + ch;
                r.accel_hit = rising;
                r.decel_hit = !rising;
            end
            else begin
                r.applied = r.target;
            end
        end
        // final clamp pulls an out-of-range kept speed back inside the limit
        fin = clamp_mag(r.applied, speed_lim[wheel]);
        if (fin != r.applied)
            r.speed_hit = 1'b1;
        r.applied = fin;
        return r;
    endfunction

    // Work out the response word for one command word and advance the kept speeds
    function automatic wheel_rsp_t predict_rsp(opcode_t op, longint raw_l, longint raw_r,
                                               longint dt);
        wheel_rsp_t  w;
        wheel_step_t a;
        wheel_step_t b;
        w = '{default: 0};
        if (op == OP_PRESET) begin
            kept[0] = raw_l;
            kept[1] = raw_r;
        end
        else if (dt != 0) begin
            a = limit_wheel(raw_l, 0, dt);
            b = limit_wheel(raw_r, 1, dt);
            kept[0]            = a.applied;
            kept[1]            = b.applied;
            w.target_left      = speed_t'(a.target);
            w.target_right     = speed_t'(b.target);
            w.speed_flag_left  = a.speed_hit;
            w.speed_flag_right = b.speed_hit;
            w.accel_flag_left  = a.accel_hit;
            w.accel_flag_right = b.accel_hit;
            w.decel_flag_left  = a.decel_hit;
            w.decel_flag_right = b.decel_hit;
            w.result_valid     = 1'b1;
        end
        w.applied_left  = speed_t'(kept[0]);
        w.applied_right = speed_t'(kept[1]);
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            errs++;
        end
    endtask

    // Track register writes, queue predictions, compare response words
    always @(posedge clk) begin
        wheel_rsp_t due;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_idx))
                    REG_MAX_SPEED_LEFT:  speed_lim[0] = cfg_wdata;
                    REG_MAX_SPEED_RIGHT: speed_lim[1] = cfg_wdata;
                    REG_MAX_ACCEL_LEFT:  accel_lim[0] = cfg_wdata;
                    REG_MAX_ACCEL_RIGHT: accel_lim[1] = cfg_wdata;
                    REG_MAX_DECEL_LEFT:  decel_lim[0] = cfg_wdata;
                    REG_MAX_DECEL_RIGHT: decel_lim[1] = cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                wheel_rsp_due.push_back(predict_rsp(cmd.opcode, cmd.raw_left, cmd.raw_right,
                                                    cmd.step_time));
            if (rsp.valid && rsp.ready) begin
                if (wheel_rsp_due.size() == 0) begin
                    $error("response word with no command word outstanding");
                    errs++;
                end
                else begin
                    due = wheel_rsp_due.pop_front();
                    check_field("target_left", due.target_left, rsp.target_left);
                    check_field("target_right", due.target_right, rsp.target_right);
                    check_field("applied_left", due.applied_left, rsp.applied_left);
                    check_field("applied_right", due.applied_right, rsp.applied_right);
                    check_field("speed_flag_left", due.speed_flag_left, rsp.speed_flag_left);
                    check_field("speed_flag_right", due.speed_flag_right, rsp.speed_flag_right);
                    check_field("accel_flag_left", due.accel_flag_left, rsp.accel_flag_left);
                    check_field("accel_flag_right", due.accel_flag_right, rsp.accel_flag_right);
                    check_field("decel_flag_left", due.decel_flag_left, rsp.decel_flag_left);
                    check_field("decel_flag_right", due.decel_flag_right, rsp.decel_flag_right);
                    check_field("result_valid", due.result_valid, rsp.result_valid);
                end
            end
        end
        pending    <= wheel_rsp_due.size();
        mismatches <= errs;
    end

endmodule

### tb/dual_wheel_slew_limiter_test.sv
// Top of the dual wheel slew limiter testbench: clock, reset, stimulus and verdict.
module dual_wheel_slew_limiter_test;
    import dwsl_pkg::*;

    localparam speed_t RAW_TOP   = 32'sh7FFFFFFF;
    localparam speed_t RAW_BOT   = 32'sh80000000;
    localparam longint RAW_HI    = 64'sd2147483647;
    localparam longint RAW_LO    = -64'sd2147483648;
    localparam limit_t LIMIT_TOP = '1;
    localparam dtime_t DT_10MS   = 20'd10486;
    localparam dtime_t DT_MAX    = '1;
    localparam int     PHASES    = 8;
    localparam int     PHASE_LEN = 150;

    // Shapes of a random limit value
    typedef enum int {
        LIM_MODERATE,
        LIM_FULL,
        LIM_EDGE,
        LIM_TINY
    } lim_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    limit_t               cfg_wdata;
    int                   mismatches;
    int                   due_count;
    bit                   no_idle = 1'b0;
    limit_t               spd_left = '0;
    limit_t               spd_right = '0;

    dwsl_cmd_if cmd();
    dwsl_rsp_if rsp();

    dual_wheel_slew_limiter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    dwsl_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic speed_t q16(int units);
        return speed_t'(units * 65536);
    endfunction

    function automatic limit_t pick_limit(lim_kind_t kind);
        case (kind)
            LIM_MODERATE: return limit_t'($urandom_range(1 << 16, 300 << 16));
            LIM_FULL:     return limit_t'($urandom);
            LIM_EDGE:     return $urandom_range(0, 1) ? LIMIT_TOP : '0;
            default:      return limit_t'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic limit_t pick_any_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return pick_limit(LIM_MODERATE);
        if (r < 75)
            return pick_limit(LIM_FULL);
        if (r < 90)
            return pick_limit(LIM_EDGE);
        return pick_limit(LIM_TINY);
    endfunction

    // Speeds mostly within 1.5 times the wheel limit, with extremes mixed in
    function automatic speed_t pick_raw(limit_t vmax);
        longint          span;
        longint          v;
        longint unsigned u;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return speed_t'($urandom);
        if (r < 15)
            return '0;
        if (r < 19)
            return speed_t'(vmax);
        if (r < 22)
            return -speed_t'(vmax);
        span = longint'(vmax) + longint'(vmax) / 2;
        u    = {$urandom, $urandom};
        v    = longint'(u % longint'(2 * span + 1)) - span;
        if (v > RAW_HI)
            v = RAW_HI;
        if (v < RAW_LO)
            v = RAW_LO;
        return speed_t'(v);
    endfunction

    function automatic dtime_t pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return DT_MAX;
        if (r < 25)
            return dtime_t'($urandom_range(1, (1 << TIME_W) - 1));
        return dtime_t'($urandom_range(1, 65536));
    endfunction

    // Present one command word and hold it until accepted
    task automatic send_word(opcode_t op, speed_t l, speed_t r, dtime_t dt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.opcode    <= op;
        cmd.raw_left  <= l;
        cmd.raw_right <= r;
        cmd.step_time <= dt;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding response word
    task automatic settle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, limit_t val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Program all six limits; the block must be idle
    task automatic load_limits(limit_t sl, limit_t sr, limit_t al, limit_t ar,
                               limit_t dl, limit_t dr);
        write_reg(REG_MAX_SPEED_LEFT, sl);
        write_reg(REG_MAX_SPEED_RIGHT, sr);
        write_reg(REG_MAX_ACCEL_LEFT, al);
        write_reg(REG_MAX_ACCEL_RIGHT, ar);
        write_reg(REG_MAX_DECEL_LEFT, dl);
        write_reg(REG_MAX_DECEL_RIGHT, dr);
        cfg_we    <= 1'b0;
        spd_left  = sl;
        spd_right = sr;
    endtask

    // Response side: random stalls, picked after a word or now and then while idle
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else begin
                if ((rsp.valid && rsp.ready) || $urandom_range(0, 7) == 0)
                    stall = pick_gap();
                rsp.ready <= (stall == 0);
            end
        end
    end

    // Stimulus
    initial
    begin
        limit_t lims [6];
        rst_n         <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.opcode    <= OP_UPDATE;
        cmd.raw_left  <= '0;
        cmd.raw_right <= '0;
        cmd.step_time <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= REG_MAX_SPEED_LEFT;
        cfg_wdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All limits zero after reset: everything clamps to zero
        send_word(OP_UPDATE, q16(5), q16(-5), DT_10MS);
        settle();
        load_limits(q16(100), q16(40), q16(50), q16(200), q16(80), q16(20));
        // Field extremes, speed clamp and acceleration limit
        send_word(OP_UPDATE, RAW_TOP, RAW_BOT, DT_10MS);
        send_word(OP_UPDATE, q16(120), q16(-30), DT_MAX);
        // Zero step time leaves the kept speeds alone
        send_word(OP_UPDATE, '0, '0, '0);
        // Sign reversal: decay, then land on zero, then accelerate the other way
        send_word(OP_UPDATE, q16(-60), q16(10), DT_10MS);
        send_word(OP_UPDATE, q16(-60), q16(10), DT_MAX);
        send_word(OP_UPDATE, q16(-60), q16(10), DT_MAX);
        send_word(OP_UPDATE, q16(-60), q16(10), DT_MAX);
        send_word(OP_UPDATE, q16(-60), q16(10), DT_MAX);
        // Falling magnitude hits the deceleration limit
        send_word(OP_UPDATE, '0, '0, DT_10MS);
        // Preset beyond the limit, then the final clamp pulls it back
        send_word(OP_PRESET, RAW_TOP, RAW_BOT, '0);
        send_word(OP_UPDATE, '0, '0, 20'd1);
        send_word(OP_PRESET, q16(50), q16(-35), 20'd12345);
        // Command exactly at the right wheel limit
        send_word(OP_UPDATE, q16(60), q16(-40), DT_10MS);
        send_word(OP_PRESET, '0, '0, DT_MAX);
        settle();
        // Widest limits
        load_limits(LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP);
        send_word(OP_UPDATE, RAW_TOP, RAW_BOT, DT_MAX);
        send_word(OP_UPDATE, RAW_BOT, RAW_TOP, DT_MAX);
        send_word(OP_UPDATE, q16(-1), q16(1), 20'd1);
        send_word(OP_UPDATE, RAW_TOP, RAW_BOT, 20'h80000);

        // Random phases, each with its own limit setting
        for (int p = 0; p < PHASES; p++) begin
            settle();
            for (int i = 0; i < 6; i++) begin
                if (p == 2)
                    lims[i] = LIMIT_TOP;
                else if (p == 5)
                    lims[i] = (i < 2) ? pick_limit(LIM_MODERATE) : '0;
                else if (p == 7)
                    lims[i] = pick_limit(LIM_EDGE);
                else
                    lims[i] = pick_any_limit();
            end
            load_limits(lims[0], lims[1], lims[2], lims[3], lims[4], lims[5]);
            no_idle = (p == 1 || p == 6);
            for (int n = 0; n < PHASE_LEN; n++) begin
                opcode_t op;
                if ($urandom_range(0, 99) == 0)
                    settle();
                op = ($urandom_range(0, 19) == 0) ? OP_PRESET : OP_UPDATE;
                send_word(op, pick_raw(spd_left), pick_raw(spd_right), pick_dt());
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
